// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

   // Screen geometry.
   localparam int unsigned COLS         = 80;
   localparam int unsigned ROWS         = 25;
   localparam int unsigned SCREEN_CELLS = COLS * ROWS;

   // Cursor runs from 0 up to and including SCREEN_CELLS; addresses stop one short.
   localparam int unsigned CUR_W  = $clog2(SCREEN_CELLS + 1);
   localparam int unsigned ADDR_W = $clog2(SCREEN_CELLS);
   localparam int unsigned COL_W  = $clog2(COLS);

   localparam logic [CUR_W-1:0] SCREEN_END = CUR_W'(SCREEN_CELLS);
   localparam logic [CUR_W-1:0] LAST_CELL  = CUR_W'(SCREEN_CELLS - 1);
   localparam logic [CUR_W-1:0] SCROLL_LEN = CUR_W'(SCREEN_CELLS - COLS);
   localparam logic [CUR_W-1:0] COLS_CUR   = CUR_W'(COLS);
   localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLS - 1);

   localparam logic [7:0] BLANK_GLYPH = 8'h20;
   localparam logic [7:0] RESET_ATTR  = 8'h07;
   localparam logic [7:0] RESET_TITLE = 8'h0F;

   // Register indexes on the APB port.
   localparam logic REG_NORMAL_ATTR = 1'b0;
   localparam logic REG_TITLE_ATTR  = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] glyph;
   } cell_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      cell_type data;
   } mem_wr_type;

   typedef enum logic [1:0] {
      OP_PUT     = 2'd0,
      OP_NEWLINE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL,
      ST_FILL,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/tcw_screen_mem.sv =====
module tcw_screen_mem (
   input  logic                clock,
   input  tcw_pkg::mem_wr_type wr,
   input  logic                rd_en,
   input  tcw_pkg::addr_type   rd_addr,
   output tcw_pkg::cell_type   rd_data
);
   import tcw_pkg::*;

   cell_type screen_mem [SCREEN_CELLS];
   cell_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         screen_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= screen_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer: a character/attribute screen of COLS x ROWS cells and a cursor.
// Items arrive on the req_ channel (valid/ready) as one of four operations: put a
// character, move to the start of the next line, clear the screen, or read one cell.
// Every item produces exactly one transfer on the rsp_ channel, which carries the new
// cursor position, a scroll flag and, for a read, the cell's character and attribute.
// Steps per item: next line and read go straight to the result, a put writes its cell,
// a put that scrolls first makes one copy pass over the screen memory and then fills
// the last row, and a clear fills every cell. The single-port-write screen memory means
// that every scroll or clear touches one cell per cycle. One item is in work at a
// time; req_ready is high only while the engine waits for an item.
// The result sits in an output register, so a new item can be accepted while the
// previous result still waits on a stalled receiver; the new item then finishes its
// work and holds until the output register is free.
// Reset clears the cursor, restores the attribute registers and starts a pass that
// writes a space with attribute 0x07 into every cell. No item is accepted during that
// pass; APB writes are taken at any time.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_ch,
   input  logic        req_is_title,
   input  logic [10:0] req_cell_index,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_cursor_pos,
   output logic        rsp_scrolled,
   output logic [7:0]  rsp_read_char,
   output logic [7:0]  rsp_read_attr,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tcw_pkg::*;

   // Control state.
   state_type         state_ff, state_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CUR_W-1:0]  ptr_ff, ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item and working payload.
   op_type            op_ff, op_in;
   logic [7:0]        ch_ff, ch_in;
   logic              title_ff, title_in;
   logic [7:0]        fill_attr_ff, fill_attr_in;
   logic              scrolled_ff, scrolled_in;
   logic              rd_ok_ff, rd_ok_in;

   // Output register payload.
   logic [10:0]       rsp_cursor_ff, rsp_cursor_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_attr_ff, rsp_attr_in;

   // Configuration registers.
   logic [7:0]        normal_attr_ff;
   logic [7:0]        title_attr_ff;

   // Screen memory ports.
   mem_wr_type        mem_wr;
   logic              mem_rd_en;
   addr_type          mem_rd_addr;
   cell_type          mem_rd_data;

   logic [CUR_W:0]    nl_next;
   logic              csr_write;

   tcw_screen_mem u_screen_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // APB register file. pready is tied high, so every access completes in its
   // access cycle. The register index is taken from the word address bit.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_attr_ff <= RESET_ATTR;
         title_attr_ff  <= RESET_TITLE;
      end else if (csr_write) begin
         case (paddr[2])
            REG_NORMAL_ATTR: normal_attr_ff <= pwdata[7:0];
            REG_TITLE_ATTR:  title_attr_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_NORMAL_ATTR: prdata = {24'd0, normal_attr_ff};
         REG_TITLE_ATTR:  prdata = {24'd0, title_attr_ff};
         default:         prdata = '0;
      endcase
   end

   // The start of the next row comes from the column counter, so no divider is
   // needed. The result saturates at the end of the screen.
   assign nl_next = {1'b0, cursor_ff} - (CUR_W + 1)'(col_ff) + (CUR_W + 1)'(COLS);

   always_comb begin
      state_in        = state_ff;
      cursor_in       = cursor_ff;
      col_in          = col_ff;
      ptr_in          = ptr_ff;
      op_in           = op_ff;
      ch_in           = ch_ff;
      title_in        = title_ff;
      fill_attr_in    = fill_attr_ff;
      scrolled_in     = scrolled_ff;
      rd_ok_in        = rd_ok_ff;

      // The output register empties when the receiver takes the transfer.
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;

      mem_wr          = '0;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = '0;
      req_ready       = 1'b0;

      case (state_ff)
         ST_INIT: begin
            // Clearing pass after reset, one cell per cycle.
            mem_wr.en   = 1'b1;
            mem_wr.addr = ptr_ff[ADDR_W-1:0];
            mem_wr.data = '{attr: RESET_ATTR, glyph: BLANK_GLYPH};
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = op_type'(req_op);
               ch_in       = req_ch;
               title_in    = req_is_title;
               scrolled_in = 1'b0;
               rd_ok_in    = 1'b0;
               case (op_type'(req_op))
                  OP_PUT: begin
                     if (cursor_ff >= SCREEN_END) begin
                        ptr_in      = '0;
                        scrolled_in = 1'b1;
                        state_in    = ST_SCROLL;
                     end else begin
                        state_in = ST_PUT;
                     end
                  end
                  OP_NEWLINE: begin
                     cursor_in = (nl_next > {1'b0, SCREEN_END}) ? SCREEN_END
                                                                : nl_next[CUR_W-1:0];
                     col_in    = '0;
                     state_in  = ST_DONE;
                  end
                  OP_CLEAR: begin
                     fill_attr_in = normal_attr_ff;
                     ptr_in       = '0;
                     cursor_in    = '0;
                     col_in       = '0;
                     state_in     = ST_FILL;
                  end
                  OP_READ: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(req_cell_index);
                     rd_ok_in    = CUR_W'(req_cell_index) < SCREEN_END;
                     state_in    = ST_DONE;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCROLL: begin
            // Copy pass: read the cell one row below, write it back in the next cycle
            // one row up. Writes always trail the reads, so no cell is read after
            // it has been overwritten.
            if (ptr_ff < SCROLL_LEN) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ADDR_W'(ptr_ff + COLS_CUR);
            end
            if (ptr_ff != '0) begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = ADDR_W'(ptr_ff - 1'b1);
               mem_wr.data = mem_rd_data;
            end
            if (ptr_ff == SCROLL_LEN) begin
               // The last row is blanked next; the cursor moves up one row.
               fill_attr_in = normal_attr_ff;
               cursor_in    = (cursor_ff >= COLS_CUR) ? cursor_ff - COLS_CUR : '0;
               state_in     = ST_FILL;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_FILL: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = ptr_ff[ADDR_W-1:0];
            mem_wr.data = '{attr: fill_attr_ff, glyph: BLANK_GLYPH};
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = (op_ff == OP_PUT) ? ST_PUT : ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_PUT: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = ADDR_W'(cursor_ff);
            mem_wr.data = '{attr: title_ff ? title_attr_ff : normal_attr_ff, glyph: ch_ff};
            cursor_in   = cursor_ff + 1'b1;
            col_in      = (col_ff == LAST_COL) ? '0 : col_ff + 1'b1;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            // Wait here while a previous result still sits in the output register.
            // The read data stays in the memory's output register meanwhile.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_cursor_in   = 11'(cursor_ff);
               rsp_scrolled_in = scrolled_ff;
               rsp_char_in     = rd_ok_ff ? mem_rd_data.glyph : '0;
               rsp_attr_in     = rd_ok_ff ? mem_rd_data.attr : '0;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cursor_ff    <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      ch_ff           <= ch_in;
      title_ff        <= title_in;
      fill_attr_ff    <= fill_attr_in;
      scrolled_ff     <= scrolled_in;
      rd_ok_ff        <= rd_ok_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_read_attr  = rsp_attr_ff;

endmodule

// ===== rtl/tcw_checker.sv =====
module tcw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_cursor_pos,
   input logic        rsp_scrolled,
   input logic [7:0]  rsp_read_char,
   input logic [7:0]  rsp_read_attr
);
   import tcw_pkg::*;

   // Reset starts the clearing pass and empties the output register.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("item accepted or result shown right after reset");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_pos <= 11'(SCREEN_CELLS))
      else $error("cursor beyond the end of the screen");

   // A scroll only happens on a put at the end of the screen, which then lands
   // one cell into the last row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_pos == 11'(SCREEN_CELLS - COLS + 1))
      else $error("scrolled put left the cursor in the wrong place");

   a_scroll_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_read_char == 8'd0 && rsp_read_attr == 8'd0)
      else $error("scrolled put returned read data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_scrolled) && $stable(rsp_read_char) && $stable(rsp_read_attr))
      else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import tcw_pkg::*;

   // One result transfer as the console reports it: the cursor after the item,
   // the scroll flag and, for a read, the cell's character and attribute.
   typedef struct packed {
      logic [10:0] cursor;
      logic        scrolled;
      logic [7:0]  glyph;
      logic [7:0]  attr;
   } report_type;

   // One line of the directed table. A row can repeat its item, and where the
   // expected report is obvious it is written into the row by hand.
   typedef struct {
      op_type      op;
      logic [7:0]  ch;
      logic        title;
      logic [10:0] idx;
      int          reps;
      bit          typed;
      report_type  want;
   } directed_row_type;

   localparam int RANDOM_ITEMS = 700;
   localparam int PHASES       = 5;

   // Signals toward the block. Every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_PUT;
   logic [7:0]  req_ch = '0;
   logic        req_is_title = 1'b0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [10:0] rsp_cursor_pos;
   logic        rsp_scrolled;
   logic [7:0]  rsp_read_char;
   logic [7:0]  rsp_read_attr;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Shadow copy of the console: screen memory, cursor and both attribute registers.
   cell_type    shadow_screen [SCREEN_CELLS];
   int unsigned shadow_cursor;
   logic [7:0]  shadow_normal;
   logic [7:0]  shadow_title;

   // Reports still owed by the block, oldest first.
   report_type       due_reports [$];
   directed_row_type directed_rows [$];

   int  mismatch_count = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  scroll_count = 0;
   int  op_count [4] = '{0, 0, 0, 0};
   int  settings_used = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;
   report_type got_rsp;
   report_type want_rsp;

   text_console_writer uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .req_is_title  (req_is_title),
      .req_cell_index(req_cell_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_scrolled  (rsp_scrolled),
      .rsp_read_char (rsp_read_char),
      .rsp_read_attr (rsp_read_attr),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every mismatch goes through here. Only the first 30 are printed so that a
   // badly broken design cannot flood the log, but all of them are counted.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 30) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // Idle lengths for either side, drawn from three bands: most often the shortest,
   // sometimes the middle one, and now and then the longest stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 94) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic void blank_screen(input logic [7:0] attr);
      for (int i = 0; i < SCREEN_CELLS; i++) begin
         shadow_screen[i].glyph = BLANK_GLYPH;
         shadow_screen[i].attr  = attr;
      end
   endfunction

   // Applies one item to the shadow console and returns the report the block
   // owes for it.
   function automatic report_type screen_step(input op_type op, input logic [7:0] ch,
                                              input logic title, input logic [10:0] idx);
      report_type  r;
      int unsigned next_row;
      r = '0;
      case (op)
         OP_PUT: begin
            // A put with the cursor past the end scrolls first: every row moves up,
            // the bottom row is blanked in the current normal attribute, and the
            // cursor steps back one row.
            if (shadow_cursor >= SCREEN_CELLS) begin
               for (int i = 0; i < SCREEN_CELLS - COLS; i++) begin
                  shadow_screen[i] = shadow_screen[i + COLS];
               end
               for (int i = SCREEN_CELLS - COLS; i < SCREEN_CELLS; i++) begin
                  shadow_screen[i].glyph = BLANK_GLYPH;
                  shadow_screen[i].attr  = shadow_normal;
               end
               shadow_cursor = (shadow_cursor >= COLS) ? shadow_cursor - COLS : 0;
               r.scrolled = 1'b1;
            end
            if (shadow_cursor < SCREEN_CELLS) begin
               shadow_screen[shadow_cursor].glyph = ch;
               shadow_screen[shadow_cursor].attr  = title ? shadow_title : shadow_normal;
               shadow_cursor++;
            end
         end
         OP_NEWLINE: begin
            // Start of the following row, held at the screen size without scrolling.
            next_row = (shadow_cursor / COLS + 1) * COLS;
            shadow_cursor = (next_row > SCREEN_CELLS) ? SCREEN_CELLS : next_row;
         end
         OP_CLEAR: begin
            blank_screen(shadow_normal);
            shadow_cursor = 0;
         end
         default: begin
            // Reads beyond the screen return zeros.
            if (idx < SCREEN_CELLS) begin
               r.glyph = shadow_screen[idx].glyph;
               r.attr  = shadow_screen[idx].attr;
            end
         end
      endcase
      r.cursor = 11'(shadow_cursor);
      return r;
   endfunction

   // Presents one item, holds it until the transfer, then records what the block
   // owes for it. The idle gap that follows, if any, is taken here as well; with
   // no gap, valid simply stays high for the next item.
   task automatic send_item(input op_type op, input logic [7:0] ch, input logic title,
                            input logic [10:0] idx, input bit typed,
                            input report_type typed_rsp);
      report_type predicted;
      int         gap;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_ch         <= ch;
      req_is_title   <= title;
      req_cell_index <= idx;
      do @(posedge clock); while (!req_ready);
      predicted = screen_step(op, ch, title, idx);
      due_reports.push_back(typed ? typed_rsp : predicted);
      op_count[op]++;
      if (predicted.scrolled) begin
         scroll_count++;
      end
      items_sent++;
      gap = (!quiet && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Reads often land on recently written cells, otherwise anywhere on the
   // screen, and sometimes past its end.
   function automatic logic [10:0] pick_read_index();
      int          r;
      int unsigned hi;
      int unsigned lo;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return 11'($urandom_range(SCREEN_CELLS, 2047));
      end
      if (r < 55 && shadow_cursor > 0) begin
         hi = ((shadow_cursor > SCREEN_CELLS) ? SCREEN_CELLS : shadow_cursor) - 1;
         lo = (hi >= COLS) ? hi - COLS : 0;
         return 11'($urandom_range(lo, hi));
      end
      return 11'($urandom_range(0, SCREEN_CELLS - 1));
   endfunction

   // Random payload around a chosen operation; fields an operation ignores
   // still get random values.
   task automatic send_random(input op_type op);
      logic [10:0] idx;
      idx = (op == OP_READ) ? pick_read_index() : 11'($urandom_range(0, 2047));
      send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx,
                1'b0, '0);
   endtask

   // One line of text as a console driver would produce it: a run of puts, the
   // odd read in between, and usually a newline at the end; rarely a clear instead.
   // Short and empty lines dominate so that the cursor reaches the bottom and scrolls
   // often. Full lines land exactly on the last cell; overlong ones wrap or scroll.
   task automatic text_line();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_random(OP_CLEAR);
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         len = $urandom_range(0, 2);
      end else if (r < 85) begin
         len = $urandom_range(3, 16);
      end else if (r < 93) begin
         len = COLS;
      end else begin
         len = $urandom_range(COLS + 1, COLS + 15);
      end
      for (int k = 0; k < len; k++) begin
         send_random(OP_PUT);
         if ($urandom_range(0, 99) < 8) begin
            send_random(OP_READ);
         end
      end
      if ($urandom_range(0, 99) < 85) begin
         send_random(OP_NEWLINE);
      end
      if ($urandom_range(0, 99) < 40) begin
         send_random(OP_READ);
      end
   endtask

   // Stops sending and waits until every owed report has arrived. The block
   // answers every item, so it is then idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register access: a setup phase, an access phase, and an idle phase
   // afterwards so that back-to-back calls never touch psel twice in a step.
   // A write updates the shadow register; a read is checked against it.
   task automatic csr_access(input bit wr, input logic regsel, input logic [7:0] value);
      logic [7:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {regsel, 2'b00};
      pwdata  <= {24'($urandom()), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) begin
         if (regsel == REG_TITLE_ATTR) begin
            shadow_title = value;
         end else begin
            shadow_normal = value;
         end
      end else begin
         want = (regsel == REG_TITLE_ATTR) ? shadow_title : shadow_normal;
         if (prdata[7:0] !== want) begin
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      regsel, prdata[7:0], want));
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void plan(input op_type op, input logic [7:0] ch, input logic title,
                                input logic [10:0] idx, input int reps, input bit typed,
                                input int cur, input logic scr, input logic [7:0] rc,
                                input logic [7:0] ra);
      directed_row_type d;
      d.op    = op;
      d.ch    = ch;
      d.title = title;
      d.idx   = idx;
      d.reps  = reps;
      d.typed = typed;
      d.want  = '{11'(cur), scr, rc, ra};
      directed_rows.push_back(d);
   endfunction

   // The receiver stalls at random, in stretches of the same lengths the sender
   // uses. During the quiet phase it starts no new stall.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every result transfer is compared field by field with the oldest report owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_rsp = '{rsp_cursor_pos, rsp_scrolled, rsp_read_char, rsp_read_attr};
         if (due_reports.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no item pending",
                                      results_seen));
         end else begin
            want_rsp = due_reports.pop_front();
            if (got_rsp.cursor !== want_rsp.cursor) begin
               report_mismatch($sformatf("result %0d: cursor_pos %0d, expected %0d",
                                         results_seen, got_rsp.cursor, want_rsp.cursor));
            end
            if (got_rsp.scrolled !== want_rsp.scrolled) begin
               report_mismatch($sformatf("result %0d: scrolled %0b, expected %0b",
                                         results_seen, got_rsp.scrolled,
                                         want_rsp.scrolled));
            end
            if (got_rsp.glyph !== want_rsp.glyph) begin
               report_mismatch($sformatf("result %0d: read_char %0h, expected %0h",
                                         results_seen, got_rsp.glyph, want_rsp.glyph));
            end
            if (got_rsp.attr !== want_rsp.attr) begin
               report_mismatch($sformatf("result %0d: read_attr %0h, expected %0h",
                                         results_seen, got_rsp.attr, want_rsp.attr));
            end
         end
         results_seen++;
      end
   end

   // Hard stop in case the block hangs. The slowest legal run, with every item
   // scrolling and both sides at their longest gaps, stays well below this.
   initial begin
      #200_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Main sequence.
   initial begin
      logic [7:0] normal_val;
      logic [7:0] title_val;
      int         phase_start;

      blank_screen(RESET_ATTR);
      shadow_cursor = 0;
      shadow_normal = RESET_ATTR;
      shadow_title  = RESET_TITLE;

      // Directed table. Rows with typed expectations follow from the reset state
      // or from the boundaries; the rest are predicted.
      // Fresh screen: first and last cell, then reads past the end return zeros.
      plan(OP_READ,    8'h00, 1'b0, 11'd0,    1, 1'b1, 0,    1'b0, BLANK_GLYPH, RESET_ATTR);
      plan(OP_READ,    8'hFF, 1'b1, 11'd1999, 1, 1'b1, 0,    1'b0, BLANK_GLYPH, RESET_ATTR);
      plan(OP_READ,    8'h00, 1'b0, 11'd2000, 1, 1'b1, 0,    1'b0, 8'h00, 8'h00);
      plan(OP_READ,    8'h5A, 1'b1, 11'd2047, 1, 1'b1, 0,    1'b0, 8'h00, 8'h00);
      // Extreme characters in both attributes, then read back.
      plan(OP_PUT,     8'hFF, 1'b1, 11'd2047, 1, 1'b1, 1,    1'b0, 8'h00, 8'h00);
      plan(OP_PUT,     8'h00, 1'b0, 11'd0,    1, 1'b1, 2,    1'b0, 8'h00, 8'h00);
      plan(OP_READ,    8'h00, 1'b0, 11'd0,    1, 1'b1, 2,    1'b0, 8'hFF, RESET_TITLE);
      plan(OP_READ,    8'h00, 1'b0, 11'd1,    1, 1'b1, 2,    1'b0, 8'h00, RESET_ATTR);
      // Newline from the middle of a row, then down to the bottom, then once more
      // to show that the cursor saturates at the screen size.
      plan(OP_NEWLINE, 8'h00, 1'b0, 11'd0,    1, 1'b1, 80,   1'b0, 8'h00, 8'h00);
      plan(OP_NEWLINE, 8'hA5, 1'b1, 11'h555, 24, 1'b0, 0,    1'b0, 8'h00, 8'h00);
      plan(OP_NEWLINE, 8'h00, 1'b0, 11'd0,    1, 1'b1, 2000, 1'b0, 8'h00, 8'h00);
      // A put at the saturated cursor scrolls one row before writing.
      plan(OP_PUT,     8'h41, 1'b1, 11'd0,    1, 1'b1, 1921, 1'b1, 8'h00, 8'h00);
      plan(OP_READ,    8'h00, 1'b0, 11'd1920, 1, 1'b1, 1921, 1'b0, 8'h41, RESET_TITLE);
      plan(OP_READ,    8'h00, 1'b0, 11'd1999, 1, 1'b1, 1921, 1'b0, BLANK_GLYPH, RESET_ATTR);
      plan(OP_READ,    8'h00, 1'b0, 11'd0,    1, 1'b0, 0,    1'b0, 8'h00, 8'h00);
      // Clear resets the cursor and blanks the screen.
      plan(OP_CLEAR,   8'h00, 1'b0, 11'd0,    1, 1'b1, 0,    1'b0, 8'h00, 8'h00);
      plan(OP_READ,    8'h00, 1'b0, 11'd1920, 1, 1'b1, 0,    1'b0, BLANK_GLYPH, RESET_ATTR);

      // Synchronous reset first. The block then runs its own clearing pass; items simply
      // wait on req_ready until it is done.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Both registers must read back their reset values.
      csr_access(1'b0, REG_NORMAL_ATTR, 8'h00);
      csr_access(1'b0, REG_TITLE_ATTR, 8'h00);
      settings_used++;

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].reps; k++) begin
            send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].title,
                      directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random part in phases. Before each phase the sender pauses until every
      // report is in, then new attributes are written and read back. The first
      // two phases use the extremes; one phase runs with no idling at all.
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin
               normal_val = 8'h00;
               title_val  = 8'hFF;
            end
            1: begin
               normal_val = 8'hFF;
               title_val  = 8'h00;
            end
            default: begin
               normal_val = 8'($urandom_range(0, 255));
               title_val  = 8'($urandom_range(0, 255));
            end
         endcase
         csr_access(1'b1, REG_NORMAL_ATTR, normal_val);
         csr_access(1'b1, REG_TITLE_ATTR, title_val);
         csr_access(1'b0, REG_NORMAL_ATTR, 8'h00);
         csr_access(1'b0, REG_TITLE_ATTR, 8'h00);
         settings_used++;
         quiet = (p == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            text_line();
         end
      end
      quiet = 1'b0;

      // Let everything come back, then give the block time to show any stray
      // result, allowing for its longest operation.
      wait_drained();
      repeat (SCREEN_CELLS + 20) @(posedge clock);
      if (due_reports.size() != 0) begin
         report_mismatch($sformatf("%0d reports never arrived", due_reports.size()));
      end

      $display("Covered %0d items: %0d puts with %0d scrolls, %0d newlines, %0d clears,",
               items_sent, op_count[OP_PUT], scroll_count, op_count[OP_NEWLINE],
               op_count[OP_CLEAR]);
      $display("%0d reads, %0d results checked, over %0d attribute settings.",
               op_count[OP_READ], results_seen, settings_used);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tcw_pkg.sv
rtl/tcw_screen_mem.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/testbench.sv
